>>> src/strip_detector_pixel_matcher_unit_macros.svh
// Assertion macros for the strip pixel matcher checker.
// Included by files that hold concurrent assertions; no other dependencies.
`ifndef STRIP_DETECTOR_PIXEL_MATCHER_UNIT_MACROS_SVH
`define STRIP_DETECTOR_PIXEL_MATCHER_UNIT_MACROS_SVH

// same-cycle implication
`define SDPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SDPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/sdpm_pkg.sv
// Types and constants of the strip pixel matcher.
// Used by sdpm_pair_chk and strip_detector_pixel_matcher_unit; no dependencies.
`timescale 1ns / 1ps

package sdpm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_WINDOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_FACTOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_PREF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MULTI_HIT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_SHARED   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_COUNT  = 3'd6;

    localparam logic [15:0] RST_TIME_WINDOW   = 16'd75;
    localparam logic [15:0] RST_ENERGY_FACTOR = 16'd29491;
    localparam logic [19:0] RST_ENERGY_OFFSET = 20'd0;
    localparam logic [5:0]  RST_SECTOR_COUNT  = 6'd32;

    typedef struct packed {
        logic [4:0]  strip;
        logic [3:0]  pos;
        logic [19:0] energy;
        logic [31:0] tstamp;
    } t_hit;

    typedef struct packed {
        logic [4:0]  ring;
        logic [4:0]  sector;
        logic [19:0] energy;
        logic [31:0] tstamp;
        logic [3:0]  pos;
        logic        by_sector;
    } t_pix;

    typedef struct packed {
        logic [15:0] time_window;
        logic [15:0] energy_factor;
        logic [19:0] energy_offset;
        logic        sector_pref;
        logic        multi_hit;
        logic        keep_shared;
        logic [5:0]  sector_count;
    } t_cfg;

    typedef struct packed {
        logic t1_ok;
        logic t2_ok;
        logic e_ok;
    } t_chk;

endpackage

>>> src/sdpm_pair_chk.sv
// Time window and two-way energy agreement checks for one center hit.
// Depends on sdpm_pkg.
`timescale 1ns / 1ps

module sdpm_pair_chk (
    input  sdpm_pkg::t_cfg i_cfg,
    input  sdpm_pkg::t_hit i_c,
    input  logic [31:0]    i_t1,
    input  logic [31:0]    i_t2,
    input  logic [20:0]    i_sum,
    output sdpm_pkg::t_chk o_chk
);

    logic [19:0]        win10;
    logic [31:0]        d1;
    logic [31:0]        d2;
    logic signed [22:0] off_x;
    logic signed [22:0] da;
    logic signed [22:0] db;
    logic signed [39:0] pa;
    logic signed [39:0] pb;
    logic signed [39:0] ra;
    logic signed [39:0] rb;

    assign win10 = ({4'b0, i_cfg.time_window} << 3) + ({4'b0, i_cfg.time_window} << 1);
    assign d1 = (i_c.tstamp >= i_t1) ? (i_c.tstamp - i_t1) : (i_t1 - i_c.tstamp);
    assign d2 = (i_c.tstamp >= i_t2) ? (i_c.tstamp - i_t2) : (i_t2 - i_c.tstamp);

    assign off_x = $signed({{3{i_cfg.energy_offset[19]}}, i_cfg.energy_offset});
    assign da    = $signed({3'b0, i_c.energy}) - off_x;
    assign db    = $signed({2'b0, i_sum}) - off_x;
    assign pa    = da * $signed({1'b0, i_cfg.energy_factor});
    assign pb    = db * $signed({1'b0, i_cfg.energy_factor});
    assign ra    = $signed({5'b0, i_c.energy, 15'b0});
    assign rb    = $signed({4'b0, i_sum, 15'b0});

    assign o_chk.t1_ok = {d1, 4'b0} < {16'b0, win10};
    assign o_chk.t2_ok = {d2, 4'b0} < {16'b0, win10};
    assign o_chk.e_ok  = (pa < rb) && (pb < ra);

endmodule

>>> src/strip_detector_pixel_matcher_unit.sv
// Strip pixel matcher top level: hit stores, matching sequencer, pixel buffer.
// Depends on sdpm_pkg and sdpm_pair_chk.
`timescale 1ns / 1ps

// A hit is taken when i_start is high and o_busy low. A hit with i_last_hit high
// raises o_busy while the event is matched: a setup state, then a read, capture and
// check state per ring/sector pair in the primary pass. Each shared pass has states for
// the free-hit test, for each used hit skipped or loop end, for the read of each unused
// hit, for each same-position triple and for the second pixel when a triple gives two
// pixels, as the hit stores have registered reads. The pixels of the event then leave
// one per cycle from the pixel buffer, o_result_stb marking each; the receiver cannot
// stall, so every strobed cycle is a transaction. An event without pixels gives one
// result with o_pixel_valid low. o_busy drops in the cycle of the final result.
module strip_detector_pixel_matcher_unit #(
    parameter int MAX_HITS   = 8,
    parameter int MAX_PIXELS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_func,
    input  logic [4:0]  i_strip,
    input  logic [3:0]  i_array_pos,
    input  logic [19:0] i_energy,
    input  logic [31:0] i_timestamp,
    input  logic        i_last_hit,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [sdpm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sdpm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic        o_result_stb,
    output logic [4:0]  o_pixel_ring,
    output logic [4:0]  o_pixel_sector,
    output logic [19:0] o_pixel_energy,
    output logic [31:0] o_pixel_time,
    output logic [3:0]  o_pixel_pos,
    output logic        o_defined_by,
    output logic        o_pixel_valid,
    output logic        o_overflow,
    output logic        o_last_pixel
);

    localparam int CW = $clog2(MAX_HITS + 1);
    localparam int IW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam int TW = $clog2(MAX_PIXELS + 1);
    localparam int PW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_P_INIT, S_P_RD, S_P_Q, S_P_CK, S_F_CHK,
        S_T_I, S_T_IQ, S_T_J, S_T_JQ, S_T_K, S_T_KQ, S_T_KC, S_T_KE2, S_OUT
    } t_state;

    t_state          r_state;
    sdpm_pkg::t_cfg  r_cfg;
    logic            r_mode;
    logic [CW-1:0]   r_rfill;
    logic [CW-1:0]   r_sfill;
    logic [MAX_HITS-1:0] r_rused;
    logic [MAX_HITS-1:0] r_sused;
    logic [CW-1:0]   r_i;
    logic [CW-1:0]   r_j;
    logic [CW-1:0]   r_k;
    logic [TW-1:0]   r_tally;
    logic [TW-1:0]   r_rd;
    logic            r_lost;
    sdpm_pkg::t_hit  r_c;
    sdpm_pkg::t_hit  r_hj;
    sdpm_pkg::t_hit  r_hk;
    logic [20:0]     r_sum;
    logic            r_stb;
    logic            r_empty;
    logic            r_last;
    logic            r_ovf;

    sdpm_pkg::t_hit  ring_mem [MAX_HITS];
    sdpm_pkg::t_hit  sec_mem  [MAX_HITS];
    sdpm_pkg::t_pix  pix_mem  [MAX_PIXELS];
    sdpm_pkg::t_hit  r_ring_q;
    sdpm_pkg::t_hit  r_sec_q;
    sdpm_pkg::t_pix  r_pix_q;

    sdpm_pkg::t_hit  in_hit;
    sdpm_pkg::t_hit  c_q;
    sdpm_pkg::t_hit  p_q;
    sdpm_pkg::t_chk  chk;
    sdpm_pkg::t_pix  emit_pix;
    logic            emit_en;
    logic            accept;
    logic [IW-1:0]   pair_addr;
    logic [IW-1:0]   ring_raddr;
    logic [IW-1:0]   sec_raddr;
    logic [CW-1:0]   c_fill;
    logic [CW-1:0]   p_fill;
    logic [MAX_HITS-1:0] c_used;
    logic [MAX_HITS-1:0] p_used;
    logic [CW-1:0]   free_r;
    logic [CW-1:0]   free_s;
    logic [MAX_HITS-1:0] m_i;
    logic [MAX_HITS-1:0] m_j;
    logic [MAX_HITS-1:0] m_k;
    logic [4:0]      dstrip;
    logic [4:0]      chosen;
    logic            nb;
    logic            pair_ok;
    logic            trip_ok;
    logic [TW-1:0]   rd_nx;

    assign accept      = i_start && (r_state == S_IDLE);
    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign in_hit = '{strip: i_strip, pos: i_array_pos, energy: i_energy, tstamp: i_timestamp};

    assign pair_addr  = (r_state == S_T_K) ? r_k[IW-1:0] : r_j[IW-1:0];
    assign ring_raddr = r_mode ? pair_addr : r_i[IW-1:0];
    assign sec_raddr  = r_mode ? r_i[IW-1:0] : pair_addr;

    assign c_q    = r_mode ? r_sec_q : r_ring_q;
    assign p_q    = r_mode ? r_ring_q : r_sec_q;
    assign c_fill = r_mode ? r_sfill : r_rfill;
    assign p_fill = r_mode ? r_rfill : r_sfill;
    assign c_used = r_mode ? r_sused : r_rused;
    assign p_used = r_mode ? r_rused : r_sused;

    assign m_i = MAX_HITS'(1) << r_i[IW-1:0];
    assign m_j = MAX_HITS'(1) << r_j[IW-1:0];
    assign m_k = MAX_HITS'(1) << r_k[IW-1:0];

    assign rd_nx = r_rd + 1'b1;

    always_comb begin
        free_r = '0;
        free_s = '0;
        for (int b = 0; b < MAX_HITS; b++) begin
            if ((CW'(b) < r_rfill) && !r_rused[b]) free_r = free_r + 1'b1;
            if ((CW'(b) < r_sfill) && !r_sused[b]) free_s = free_s + 1'b1;
        end
    end

    sdpm_pair_chk u_chk (
        .i_cfg (r_cfg),
        .i_c   (r_c),
        .i_t1  (r_hj.tstamp),
        .i_t2  (r_hk.tstamp),
        .i_sum (r_sum),
        .o_chk (chk)
    );

    assign pair_ok = (r_c.pos == r_hj.pos) && chk.t1_ok && chk.e_ok;
    assign trip_ok = chk.t1_ok && chk.t2_ok && chk.e_ok;
    assign dstrip  = (r_hj.strip > r_hk.strip) ? (r_hj.strip - r_hk.strip)
                                                : (r_hk.strip - r_hj.strip);
    assign nb      = (dstrip == 5'd1) ||
                     (!r_mode && ({2'b0, dstrip} == ({1'b0, r_cfg.sector_count} - 7'd1)));
    assign chosen  = (r_hk.energy < r_hj.energy) ? r_hj.strip : r_hk.strip;

    always_comb begin
        emit_en  = 1'b0;
        emit_pix = '{ring: r_c.strip, sector: r_hj.strip, energy: r_c.energy,
                     tstamp: r_c.tstamp, pos: r_c.pos, by_sector: 1'b0};
        case (r_state)
            S_P_CK: begin
                emit_en = pair_ok;
                if (r_cfg.sector_pref) begin
                    emit_pix = '{ring: r_c.strip, sector: r_hj.strip, energy: r_hj.energy,
                                 tstamp: r_hj.tstamp, pos: r_hj.pos, by_sector: 1'b1};
                end
            end
            S_T_KC: begin
                if (trip_ok) begin
                    if (nb) begin
                        emit_en  = r_cfg.keep_shared;
                        emit_pix = '{ring: r_mode ? chosen : r_c.strip,
                                     sector: r_mode ? r_c.strip : chosen,
                                     energy: r_c.energy, tstamp: r_c.tstamp,
                                     pos: r_c.pos, by_sector: r_mode};
                    end else begin
                        emit_en  = 1'b1;
                        emit_pix = '{ring: r_mode ? r_hj.strip : r_c.strip,
                                     sector: r_mode ? r_c.strip : r_hj.strip,
                                     energy: r_hj.energy, tstamp: r_hj.tstamp,
                                     pos: r_hj.pos, by_sector: !r_mode};
                    end
                end
            end
            S_T_KE2: begin
                emit_en  = 1'b1;
                emit_pix = '{ring: r_mode ? r_hk.strip : r_c.strip,
                             sector: r_mode ? r_c.strip : r_hk.strip,
                             energy: r_hk.energy, tstamp: r_hk.tstamp,
                             pos: r_hk.pos, by_sector: !r_mode};
            end
            default: ;
        endcase
    end

    // hit stores
    always_ff @(posedge i_clk) begin
        if (accept && !i_func && (r_rfill < CW'(MAX_HITS))) begin
            ring_mem[r_rfill[IW-1:0]] <= in_hit;
        end
        if (accept && i_func && (r_sfill < CW'(MAX_HITS))) begin
            sec_mem[r_sfill[IW-1:0]] <= in_hit;
        end
        r_ring_q <= ring_mem[ring_raddr];
        r_sec_q  <= sec_mem[sec_raddr];
    end

    // pixel buffer
    always_ff @(posedge i_clk) begin
        if (emit_en && (r_tally < TW'(MAX_PIXELS))) begin
            pix_mem[r_tally[PW-1:0]] <= emit_pix;
        end
        r_pix_q <= pix_mem[r_rd[PW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= '{time_window: sdpm_pkg::RST_TIME_WINDOW,
                         energy_factor: sdpm_pkg::RST_ENERGY_FACTOR,
                         energy_offset: sdpm_pkg::RST_ENERGY_OFFSET,
                         sector_pref: 1'b0, multi_hit: 1'b1, keep_shared: 1'b0,
                         sector_count: sdpm_pkg::RST_SECTOR_COUNT};
            r_mode  <= 1'b0;
            r_rfill <= '0;
            r_sfill <= '0;
            r_rused <= '0;
            r_sused <= '0;
            r_tally <= '0;
            r_lost  <= 1'b0;
            r_rd    <= '0;
            r_stb   <= 1'b0;
            r_empty <= 1'b0;
            r_last  <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_stb <= 1'b0;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    sdpm_pkg::CFG_TIME_WINDOW:   r_cfg.time_window   <= i_cfg_data[15:0];
                    sdpm_pkg::CFG_ENERGY_FACTOR: r_cfg.energy_factor <= i_cfg_data[15:0];
                    sdpm_pkg::CFG_ENERGY_OFFSET: r_cfg.energy_offset <= i_cfg_data;
                    sdpm_pkg::CFG_SECTOR_PREF:   r_cfg.sector_pref   <= i_cfg_data[0];
                    sdpm_pkg::CFG_MULTI_HIT:     r_cfg.multi_hit     <= i_cfg_data[0];
                    sdpm_pkg::CFG_KEEP_SHARED:   r_cfg.keep_shared   <= i_cfg_data[0];
                    sdpm_pkg::CFG_SECTOR_COUNT:  r_cfg.sector_count  <= i_cfg_data[5:0];
                    default: ;
                endcase
            end

            if (emit_en) begin
                if (r_tally < TW'(MAX_PIXELS)) r_tally <= r_tally + 1'b1;
                else r_lost <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (!i_func && (r_rfill < CW'(MAX_HITS))) r_rfill <= r_rfill + 1'b1;
                        if (i_func && (r_sfill < CW'(MAX_HITS))) r_sfill <= r_sfill + 1'b1;
                        if (i_last_hit) r_state <= S_P_INIT;
                    end
                end
                S_P_INIT: begin
                    r_mode <= 1'b0;
                    r_i    <= '0;
                    r_j    <= '0;
                    r_rd   <= '0;
                    if ((r_rfill == '0) || (r_sfill == '0)) r_state <= S_OUT;
                    else r_state <= S_P_RD;
                end
                S_P_RD: r_state <= S_P_Q;
                S_P_Q: begin
                    r_c     <= r_ring_q;
                    r_hj    <= r_sec_q;
                    r_hk    <= r_sec_q;
                    r_sum   <= {1'b0, r_sec_q.energy};
                    r_state <= S_P_CK;
                end
                S_P_CK: begin
                    if (pair_ok) begin
                        r_rused <= r_rused | m_i;
                        r_sused <= r_sused | m_j;
                    end
                    if (r_j + 1'b1 == r_sfill) begin
                        r_j <= '0;
                        if (r_i + 1'b1 == r_rfill) begin
                            r_state <= r_cfg.multi_hit ? S_F_CHK : S_OUT;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_P_RD;
                        end
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_P_RD;
                    end
                end
                S_F_CHK: begin
                    if ((free_r > CW'(1)) || (free_s > CW'(1))) begin
                        r_i     <= '0;
                        r_state <= S_T_I;
                    end else if (!r_mode) begin
                        r_mode <= 1'b1;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_T_I: begin
                    if (r_i == c_fill) begin
                        if (!r_mode) begin
                            r_mode  <= 1'b1;
                            r_state <= S_F_CHK;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else if (c_used[r_i[IW-1:0]]) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_state <= S_T_IQ;
                    end
                end
                S_T_IQ: begin
                    r_c     <= c_q;
                    r_j     <= '0;
                    r_state <= S_T_J;
                end
                S_T_J: begin
                    if (r_j == p_fill) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_T_I;
                    end else if (p_used[r_j[IW-1:0]]) begin
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_state <= S_T_JQ;
                    end
                end
                S_T_JQ: begin
                    r_hj <= p_q;
                    if (p_q.pos != r_c.pos) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_T_J;
                    end else begin
                        r_k     <= r_j + 1'b1;
                        r_state <= S_T_K;
                    end
                end
                S_T_K: begin
                    if (r_k == p_fill) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_T_J;
                    end else if (p_used[r_k[IW-1:0]]) begin
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_state <= S_T_KQ;
                    end
                end
                S_T_KQ: begin
                    r_hk  <= p_q;
                    r_sum <= {1'b0, r_hj.energy} + {1'b0, p_q.energy};
                    if (p_q.pos != r_hj.pos) begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_T_K;
                    end else begin
                        r_state <= S_T_KC;
                    end
                end
                S_T_KC: begin
                    if (trip_ok) begin
                        if (!r_mode) begin
                            r_rused <= r_rused | m_i;
                            r_sused <= r_sused | m_j | m_k;
                        end else begin
                            r_sused <= r_sused | m_i;
                            r_rused <= r_rused | m_j | m_k;
                        end
                    end
                    if (trip_ok && !nb) begin
                        r_state <= S_T_KE2;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_T_K;
                    end
                end
                S_T_KE2: begin
                    r_k     <= r_k + 1'b1;
                    r_state <= S_T_K;
                end
                S_OUT: begin
                    r_stb <= 1'b1;
                    if (r_tally == '0) begin
                        r_empty <= 1'b1;
                        r_last  <= 1'b1;
                        r_ovf   <= 1'b0;
                    end else begin
                        r_empty <= 1'b0;
                        r_last  <= (rd_nx == r_tally);
                        r_ovf   <= r_lost;
                        r_rd    <= rd_nx;
                    end
                    if ((r_tally == '0) || (rd_nx == r_tally)) begin
                        r_rfill <= '0;
                        r_sfill <= '0;
                        r_rused <= '0;
                        r_sused <= '0;
                        r_tally <= '0;
                        r_lost  <= 1'b0;
                        r_mode  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result_stb   = r_stb;
    assign o_pixel_ring   = r_empty ? 5'd0  : r_pix_q.ring;
    assign o_pixel_sector = r_empty ? 5'd0  : r_pix_q.sector;
    assign o_pixel_energy = r_empty ? 20'd0 : r_pix_q.energy;
    assign o_pixel_time   = r_empty ? 32'd0 : r_pix_q.tstamp;
    assign o_pixel_pos    = r_empty ? 4'd0  : r_pix_q.pos;
    assign o_defined_by   = r_empty ? 1'b0  : r_pix_q.by_sector;
    assign o_pixel_valid  = !r_empty;
    assign o_overflow     = r_ovf;
    assign o_last_pixel   = r_last;

endmodule

>>> src/sdpm_checker.sv
// Port-level checks of the strip pixel matcher, bound to the top level.
// Depends on strip_detector_pixel_matcher_unit_macros.svh and the top level.
`timescale 1ns / 1ps
`include "strip_detector_pixel_matcher_unit_macros.svh"

module sdpm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        i_last_hit,
    input logic        o_result_stb,
    input logic [4:0]  o_pixel_ring,
    input logic [19:0] o_pixel_energy,
    input logic        o_pixel_valid,
    input logic        o_overflow,
    input logic        o_last_pixel
);

    `SDPM_ASSERT_NOW(a_empty_result, i_clk, i_rst_n, o_result_stb && !o_pixel_valid, o_last_pixel && !o_overflow && o_pixel_ring == 5'd0 && o_pixel_energy == 20'd0, "empty event result malformed")
    `SDPM_ASSERT_NEXT(a_gap_after_last, i_clk, i_rst_n, o_result_stb && o_last_pixel, !o_result_stb, "result right after final transaction")
    `SDPM_ASSERT_NEXT(a_burst, i_clk, i_rst_n, o_result_stb && !o_last_pixel, o_result_stb && o_overflow == $past(o_overflow), "pixel burst broken or overflow changed")
    `SDPM_ASSERT_NEXT(a_busy_on_last, i_clk, i_rst_n, i_start && !o_busy && i_last_hit, o_busy, "busy not raised after final hit")

endmodule

bind strip_detector_pixel_matcher_unit sdpm_checker u_sdpm_checker (.*);

>>> dv/strip_detector_pixel_matcher_unit_tb.sv
// Self-checking testbench of strip_detector_pixel_matcher_unit: hits go in, pixels are
// predicted per event in the bench and compared field by field. Depends on sdpm_pkg and the RTL.
`timescale 1ns / 1ps

module strip_detector_pixel_matcher_unit_tb;

    typedef struct {
        sdpm_pkg::t_pix px;
        logic vld;
        logic ovf;
        logic lst;
    } t_pix_exp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic        i_func;
    logic [4:0]  i_strip;
    logic [3:0]  i_array_pos;
    logic [19:0] i_energy;
    logic [31:0] i_timestamp;
    logic        i_last_hit;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [sdpm_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [sdpm_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic        o_result_stb;
    logic [4:0]  o_pixel_ring;
    logic [4:0]  o_pixel_sector;
    logic [19:0] o_pixel_energy;
    logic [31:0] o_pixel_time;
    logic [3:0]  o_pixel_pos;
    logic        o_defined_by;
    logic        o_pixel_valid;
    logic        o_overflow;
    logic        o_last_pixel;

    strip_detector_pixel_matcher_unit dut (.*);

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // matcher settings as the bench sees them
    logic [15:0] cfg_tw;
    logic [15:0] cfg_ef;
    longint      cfg_eo;
    logic        cfg_pref;
    logic        cfg_mh;
    logic        cfg_ks;
    logic [5:0]  cfg_sc;

    // event state
    sdpm_pkg::t_hit ring_hits[8];
    sdpm_pkg::t_hit sect_hits[8];
    int         ring_cnt;
    int         sect_cnt;
    logic [7:0] ring_taken;
    logic [7:0] sect_taken;
    bit         pix_lost;
    t_pix_exp   event_pix[$];
    t_pix_exp   pix_expected[$];

    int send_idle_pct;
    int hits_sent;
    int events_sent;
    int pixels_seen;
    int errors;

    function automatic bit in_window(logic [31:0] a, logic [31:0] b);
        longint unsigned d;
        d = (a > b) ? a - b : b - a;
        return d * 16 < longint'(cfg_tw) * 10;
    endfunction

    function automatic bit e_agree(longint a, longint b);
        return (a - cfg_eo) * longint'(cfg_ef) < b * 32768;
    endfunction

    function automatic bit e_match(longint a, longint b);
        return e_agree(a, b) && e_agree(b, a);
    endfunction

    function automatic int free_count(logic [7:0] taken, int n);
        int c;
        c = 0;
        for (int i = 0; i < n; i++)
            if (!taken[i]) c++;
        return c;
    endfunction

    function automatic bit sect_adjacent(logic [4:0] a, logic [4:0] b);
        int d;
        d = int'(a) - int'(b);
        if (d < 0) d = -d;
        return d == 1 || d == int'(cfg_sc) - 1;
    endfunction

    function automatic void add_pixel(logic [4:0] ring, logic [4:0] sector,
                                      sdpm_pkg::t_hit src, logic by);
        t_pix_exp e;
        if (event_pix.size() >= 64) begin
            pix_lost = 1;
            return;
        end
        e.px = '{ring: ring, sector: sector, energy: src.energy, tstamp: src.tstamp,
                 pos: src.pos, by_sector: by};
        e.vld = 1;
        e.ovf = 0;
        e.lst = 0;
        event_pix = {event_pix, e};
    endfunction

    function automatic void shared_ring_match();
        longint sum;
        for (int i = 0; i < ring_cnt; i++) begin
            if (ring_taken[i]) continue;
            for (int j = 0; j < sect_cnt; j++) begin
                if (sect_taken[j] || ring_hits[i].pos != sect_hits[j].pos) continue;
                for (int k = j + 1; k < sect_cnt; k++) begin
                    sum = longint'(sect_hits[j].energy) + longint'(sect_hits[k].energy);
                    if (sect_taken[k] || sect_hits[j].pos != sect_hits[k].pos) continue;
                    if (!in_window(ring_hits[i].tstamp, sect_hits[j].tstamp) ||
                        !in_window(ring_hits[i].tstamp, sect_hits[k].tstamp)) continue;
                    if (!e_match(longint'(ring_hits[i].energy), sum)) continue;
                    if (sect_adjacent(sect_hits[j].strip, sect_hits[k].strip)) begin
                        if (cfg_ks)
                            add_pixel(ring_hits[i].strip,
                                      (sect_hits[k].energy < sect_hits[j].energy) ?
                                      sect_hits[j].strip : sect_hits[k].strip,
                                      ring_hits[i], 0);
                    end else begin
                        add_pixel(ring_hits[i].strip, sect_hits[j].strip, sect_hits[j], 1);
                        add_pixel(ring_hits[i].strip, sect_hits[k].strip, sect_hits[k], 1);
                    end
                    ring_taken[i] = 1;
                    sect_taken[j] = 1;
                    sect_taken[k] = 1;
                end
            end
        end
    endfunction

    function automatic void shared_sector_match();
        longint sum;
        int     d;
        for (int i = 0; i < sect_cnt; i++) begin
            if (sect_taken[i]) continue;
            for (int j = 0; j < ring_cnt; j++) begin
                if (ring_taken[j] || sect_hits[i].pos != ring_hits[j].pos) continue;
                for (int k = j + 1; k < ring_cnt; k++) begin
                    sum = longint'(ring_hits[j].energy) + longint'(ring_hits[k].energy);
                    d = int'(ring_hits[j].strip) - int'(ring_hits[k].strip);
                    if (ring_taken[k] || ring_hits[j].pos != ring_hits[k].pos) continue;
                    if (!in_window(sect_hits[i].tstamp, ring_hits[j].tstamp) ||
                        !in_window(sect_hits[i].tstamp, ring_hits[k].tstamp)) continue;
                    if (!e_match(longint'(sect_hits[i].energy), sum)) continue;
                    if (d == 1 || d == -1) begin
                        if (cfg_ks)
                            add_pixel((ring_hits[k].energy < ring_hits[j].energy) ?
                                      ring_hits[j].strip : ring_hits[k].strip,
                                      sect_hits[i].strip, sect_hits[i], 1);
                    end else begin
                        add_pixel(ring_hits[j].strip, sect_hits[i].strip, ring_hits[j], 0);
                        add_pixel(ring_hits[k].strip, sect_hits[i].strip, ring_hits[k], 0);
                    end
                    sect_taken[i] = 1;
                    ring_taken[j] = 1;
                    ring_taken[k] = 1;
                end
            end
        end
    endfunction

    function automatic void predict_hit(logic func, sdpm_pkg::t_hit h, logic last);
        t_pix_exp e;
        if (!func) begin
            if (ring_cnt < 8) ring_hits[ring_cnt++] = h;
        end else begin
            if (sect_cnt < 8) sect_hits[sect_cnt++] = h;
        end
        if (!last) return;
        event_pix.delete();
        pix_lost = 0;
        ring_taken = '0;
        sect_taken = '0;
        if (ring_cnt > 0 && sect_cnt > 0) begin
            for (int i = 0; i < ring_cnt; i++)
                for (int j = 0; j < sect_cnt; j++) begin
                    if (ring_hits[i].pos != sect_hits[j].pos) continue;
                    if (!in_window(ring_hits[i].tstamp, sect_hits[j].tstamp)) continue;
                    if (!e_match(longint'(ring_hits[i].energy), longint'(sect_hits[j].energy)))
                        continue;
                    if (cfg_pref)
                        add_pixel(ring_hits[i].strip, sect_hits[j].strip, sect_hits[j], 1);
                    else
                        add_pixel(ring_hits[i].strip, sect_hits[j].strip, ring_hits[i], 0);
                    ring_taken[i] = 1;
                    sect_taken[j] = 1;
                end
            if (cfg_mh) begin
                if (free_count(ring_taken, ring_cnt) > 1 || free_count(sect_taken, sect_cnt) > 1)
                    shared_ring_match();
                if (free_count(ring_taken, ring_cnt) > 1 || free_count(sect_taken, sect_cnt) > 1)
                    shared_sector_match();
            end
        end
        if (event_pix.size() == 0) begin
            e.px = '0;
            e.vld = 0;
            e.ovf = 0;
            e.lst = 1;
            event_pix = {event_pix, e};
        end else begin
            foreach (event_pix[i]) event_pix[i].ovf = pix_lost;
            event_pix[event_pix.size() - 1].lst = 1;
        end
        pix_expected = {pix_expected, event_pix};
        ring_cnt = 0;
        sect_cnt = 0;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_pix_exp e;
        if (i_rst_n && o_result_stb) begin
            pixels_seen++;
            if (pix_expected.size() == 0) begin
                $error("unexpected result transaction, ring %0d sector %0d",
                       o_pixel_ring, o_pixel_sector);
                errors++;
            end else begin
                e = pix_expected.pop_front();
                check_field("pixel_ring", e.px.ring, o_pixel_ring);
                check_field("pixel_sector", e.px.sector, o_pixel_sector);
                check_field("pixel_energy", e.px.energy, o_pixel_energy);
                check_field("pixel_time", e.px.tstamp, o_pixel_time);
                check_field("pixel_pos", e.px.pos, o_pixel_pos);
                check_field("defined_by", e.px.by_sector, o_defined_by);
                check_field("pixel_valid", e.vld, o_pixel_valid);
                check_field("overflow", e.ovf, o_overflow);
                check_field("last_pixel", e.lst, o_last_pixel);
            end
        end
    end

    task automatic send_hit(logic func, sdpm_pkg::t_hit h, logic last);
        i_start     <= 1'b1;
        i_func      <= func;
        i_strip     <= h.strip;
        i_array_pos <= h.pos;
        i_energy    <= h.energy;
        i_timestamp <= h.tstamp;
        i_last_hit  <= last;
        do @(posedge i_clk); while (o_busy);
        predict_hit(func, h, last);
        hits_sent++;
        if (last) events_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        i_start <= 1'b0;
        while (pix_expected.size() != 0 || o_busy) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [sdpm_pkg::CFG_IDX_W-1:0] idx,
                             logic [sdpm_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            sdpm_pkg::CFG_TIME_WINDOW:   cfg_tw = data[15:0];
            sdpm_pkg::CFG_ENERGY_FACTOR: cfg_ef = data[15:0];
            sdpm_pkg::CFG_ENERGY_OFFSET: cfg_eo = longint'(signed'(data[19:0]));
            sdpm_pkg::CFG_SECTOR_PREF:   cfg_pref = data[0];
            sdpm_pkg::CFG_MULTI_HIT:     cfg_mh = data[0];
            sdpm_pkg::CFG_KEEP_SHARED:   cfg_ks = data[0];
            sdpm_pkg::CFG_SECTOR_COUNT:  cfg_sc = data[5:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_cfg(logic [15:0] tw, logic [15:0] ef, logic [19:0] eo, logic pref,
                           logic mh, logic ks, logic [5:0] sc);
        cfg_write(sdpm_pkg::CFG_TIME_WINDOW, sdpm_pkg::CFG_DATA_W'(tw));
        cfg_write(sdpm_pkg::CFG_ENERGY_FACTOR, sdpm_pkg::CFG_DATA_W'(ef));
        cfg_write(sdpm_pkg::CFG_ENERGY_OFFSET, eo);
        cfg_write(sdpm_pkg::CFG_SECTOR_PREF, sdpm_pkg::CFG_DATA_W'(pref));
        cfg_write(sdpm_pkg::CFG_MULTI_HIT, sdpm_pkg::CFG_DATA_W'(mh));
        cfg_write(sdpm_pkg::CFG_KEEP_SHARED, sdpm_pkg::CFG_DATA_W'(ks));
        cfg_write(sdpm_pkg::CFG_SECTOR_COUNT, sdpm_pkg::CFG_DATA_W'(sc));
    endtask

    // one event: plausible ring/sector pairs and split charge, or pure noise when noisy is set
    task automatic send_event(int nr, int ns, bit noisy);
        sdpm_pkg::t_hit hl[$];
        logic           kind[$];
        sdpm_pkg::t_hit h;
        logic           kt;
        int             n;
        int             p;
        logic [19:0]    base_e;
        logic [31:0]    base_t;
        base_e = 20'($urandom_range(2000, 480000));
        base_t = $urandom;
        if (nr + ns == 0) ns = 1;
        for (int i = 0; i < nr + ns; i++) begin
            if (noisy) begin
                h = sdpm_pkg::t_hit'(61'({$urandom, $urandom}));
            end else begin
                h.strip  = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
                h.pos    = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(1));
                h.energy = base_e;
                if ($urandom_range(2) == 0) h.energy = base_e / 2;
                h.energy = h.energy + 20'($urandom_range(base_e / 32)) - 20'(base_e / 64);
                h.tstamp = base_t + $urandom_range(($urandom_range(4) == 0) ? 200 : 40);
            end
            hl = {hl, h};
            kind = {kind, logic'(i >= nr)};
        end
        n = hl.size();
        for (int i = n - 1; i > 0; i--) begin
            p = $urandom_range(i);
            h = hl[i]; hl[i] = hl[p]; hl[p] = h;
            kt = kind[i]; kind[i] = kind[p]; kind[p] = kt;
        end
        for (int i = 0; i < n; i++) send_hit(kind[i], hl[i], i == n - 1);
    endtask

    task automatic random_events(int target);
        int stop_at;
        stop_at = hits_sent + target;
        while (hits_sent < stop_at) begin
            if ($urandom_range(9) == 0)
                send_event($urandom_range(3), $urandom_range(3), 1);
            else if ($urandom_range(14) == 0)
                send_event($urandom_range(6, 9), $urandom_range(6, 9), 0);
            else
                send_event($urandom_range(4), $urandom_range(4), 0);
        end
    endtask

    task automatic test_directed();
        sdpm_pkg::t_hit h;
        h = '{strip: 5'd31, pos: 4'd15, energy: 20'hFFFFF, tstamp: 32'hFFFF_FFFF};
        send_hit(1'b1, h, 1'b1);
        h = '{strip: 5'd0, pos: 4'd0, energy: 20'd0, tstamp: 32'd0};
        send_hit(1'b0, h, 1'b0);
        send_hit(1'b0, h, 1'b1);
        // nine rings, the last one is dropped by the full store
        for (int i = 0; i < 9; i++) begin
            h = '{strip: 5'(i), pos: 4'd3, energy: 20'd5000, tstamp: 32'd100};
            send_hit(1'b0, h, 1'b0);
        end
        h = '{strip: 5'd9, pos: 4'd3, energy: 20'd5000, tstamp: 32'd110};
        send_hit(1'b1, h, 1'b1);
        settle();
        // wrap neighbour sectors sharing one ring, with and without keep-shared
        for (int ks = 0; ks < 2; ks++) begin
            cfg_write(sdpm_pkg::CFG_KEEP_SHARED, sdpm_pkg::CFG_DATA_W'(ks));
            h = '{strip: 5'd3, pos: 4'd2, energy: 20'd10000, tstamp: 32'd1000};
            send_hit(1'b0, h, 1'b0);
            h = '{strip: 5'd0, pos: 4'd2, energy: 20'd5000, tstamp: 32'd1004};
            send_hit(1'b1, h, 1'b0);
            h = '{strip: 5'(cfg_sc - 1), pos: 4'd2, energy: 20'd5100, tstamp: 32'd998};
            send_hit(1'b1, h, 1'b1);
            settle();
        end
        // adjacent rings sharing one sector
        h = '{strip: 5'd7, pos: 4'd1, energy: 20'd8000, tstamp: 32'd50};
        send_hit(1'b0, h, 1'b0);
        h = '{strip: 5'd8, pos: 4'd1, energy: 20'd8200, tstamp: 32'd52};
        send_hit(1'b0, h, 1'b0);
        h = '{strip: 5'd4, pos: 4'd1, energy: 20'd16100, tstamp: 32'd51};
        send_hit(1'b1, h, 1'b1);
        settle();
    endtask

    task automatic test_full_table();
        sdpm_pkg::t_hit h;
        for (int i = 0; i < 16; i++) begin
            h = '{strip: 5'(i % 8), pos: 4'd5, energy: 20'd30000, tstamp: 32'd7};
            send_hit(i >= 8, h, i == 15);
        end
        settle();
    endtask

    task automatic test_config_sweep();
        set_cfg(16'd0, 16'd29491, 20'd0, 1'b0, 1'b1, 1'b0, 6'd32);
        random_events(20);
        settle();
        set_cfg(16'hFFFF, 16'hFFFF, 20'h80000, 1'b1, 1'b0, 1'b1, 6'd2);
        random_events(20);
        settle();
        set_cfg(16'd300, 16'd0, 20'h7FFFF, 1'b0, 1'b1, 1'b1, 6'd24);
        random_events(20);
        settle();
        set_cfg(16'd120, 16'd31000, 20'd500, 1'b1, 1'b1, 1'b0, 6'd8);
        random_events(20);
        settle();
    endtask

    task automatic test_random_phases();
        set_cfg(16'd75, 16'd29491, 20'd0, 1'b0, 1'b1, 1'b1, 6'd32);
        send_idle_pct = 28;
        random_events(110);
        settle();
        cfg_write(sdpm_pkg::CFG_SECTOR_PREF, sdpm_pkg::CFG_DATA_W'(1));
        send_idle_pct = 87;
        random_events(110);
        settle();
        set_cfg(sdpm_pkg::RST_TIME_WINDOW, sdpm_pkg::RST_ENERGY_FACTOR,
                sdpm_pkg::RST_ENERGY_OFFSET, 1'b0, 1'b1, 1'b0,
                sdpm_pkg::RST_SECTOR_COUNT);
        send_idle_pct = 0;
        random_events(110);
        settle();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_func      <= 1'b0;
        i_strip     <= '0;
        i_array_pos <= '0;
        i_energy    <= '0;
        i_timestamp <= '0;
        i_last_hit  <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        cfg_tw = sdpm_pkg::RST_TIME_WINDOW;
        cfg_ef = sdpm_pkg::RST_ENERGY_FACTOR;
        cfg_eo = 0;
        cfg_pref = 1'b0;
        cfg_mh = 1'b1;
        cfg_ks = 1'b0;
        cfg_sc = sdpm_pkg::RST_SECTOR_COUNT;
        ring_cnt = 0;
        sect_cnt = 0;
        send_idle_pct = 28;
        hits_sent = 0;
        events_sent = 0;
        pixels_seen = 0;
        errors = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_table();
        test_config_sweep();
        test_random_phases();
        $display("covered %0d hits in %0d events, %0d result transactions checked",
                 hits_sent, events_sent, pixels_seen);
        $display("all registers at extremes, shared ring/sector passes, full store and table");
        if (errors == 0)
            $display("strip_detector_pixel_matcher_unit_tb: done, clean");
        else
            $display("strip_detector_pixel_matcher_unit_tb: done, errors");
        $finish;
    end

    initial begin
        #40000000;
        $display("timeout waiting for the matcher");
        $display("strip_detector_pixel_matcher_unit_tb: done, errors");
        $finish;
    end

endmodule
